[hw/rtl/stl_pkg.sv]
// stl_pkg: shared types and constants for the shell token lexer.
// Character codes, token class codes and the character flag struct.
// No dependencies.
package stl_pkg;

  localparam int unsigned OffsetBitsDef = 16;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned ClassW        = 3;

  typedef enum logic [ClassW-1:0] {
    CLS_OTHER    = 3'd0,
    CLS_SPACE    = 3'd1,
    CLS_NEWLINE  = 3'd2,
    CLS_OPTION   = 3'd3,
    CLS_FILE     = 3'd4,
    CLS_WORD     = 3'd5,
    CLS_VARIABLE = 3'd6,
    CLS_IDLE     = 3'd7
  } class_e;

  localparam logic [ByteW-1:0] ChNul    = 8'h00;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChNl     = 8'h0A;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChDash   = 8'h2D;
  localparam logic [ByteW-1:0] ChDot    = 8'h2E;
  localparam logic [ByteW-1:0] ChSlash  = 8'h2F;
  localparam logic [ByteW-1:0] ChEq     = 8'h3D;
  localparam logic [ByteW-1:0] ChUpperA = 8'h41;
  localparam logic [ByteW-1:0] ChUnder  = 8'h5F;
  localparam logic [ByteW-1:0] ChLowerZ = 8'h7A;

  typedef struct packed {
    logic zero;
    logic space;
    logic newline;
    logic letter;
    logic word_start;
    logic word_char;
    logic option_char;
    logic file_char;
    logic dash;
    logic file_start;
    logic dollar;
  } char_flags_t;

endpackage

[hw/rtl/stl_if.sv]
// stl_if: valid/ready stream interfaces for the shell token lexer.
// stl_byte_if carries input bytes, stl_token_if carries labeled results.
// Depends on stl_pkg.
interface stl_byte_if;
  logic                      valid;
  logic                      ready;
  logic [stl_pkg::ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface stl_token_if #(
  parameter int unsigned OFFSET_BITS = stl_pkg::OffsetBitsDef
);
  logic                       valid;
  logic                       ready;
  logic [stl_pkg::ClassW-1:0] token_class;
  logic                       token_start;
  logic [OFFSET_BITS-1:0]     token_offset;
  logic                       end_of_input;

  modport source (output valid, output token_class, output token_start,
                  output token_offset, output end_of_input, input ready);
  modport sink   (input valid, input token_class, input token_start,
                  input token_offset, input end_of_input, output ready);
endinterface

[hw/rtl/stl_char_decode.sv]
// stl_char_decode: sorts one byte into the lexer's character sets.
// Pure combinational decode. Depends on stl_pkg.
module stl_char_decode (
  input  logic [stl_pkg::ByteW-1:0] byte_i,
  output stl_pkg::char_flags_t      flags_o
);

  logic letter, word_start, word_char;

  always_comb begin
    letter     = (byte_i >= stl_pkg::ChUpperA) && (byte_i <= stl_pkg::ChLowerZ);
    word_start = letter || (byte_i == stl_pkg::ChUnder);
    word_char  = word_start || (byte_i == stl_pkg::ChDollar) || (byte_i == stl_pkg::ChDash);

    flags_o.zero        = (byte_i == stl_pkg::ChNul);
    flags_o.space       = (byte_i == stl_pkg::ChSpace) || (byte_i == stl_pkg::ChTab);
    flags_o.newline     = (byte_i == stl_pkg::ChNl);
    flags_o.letter      = letter;
    flags_o.word_start  = word_start;
    flags_o.word_char   = word_char;
    flags_o.option_char = word_char || (byte_i == stl_pkg::ChEq);
    flags_o.file_char   = word_char || (byte_i == stl_pkg::ChDot)
                          || (byte_i == stl_pkg::ChSlash);
    flags_o.dash        = (byte_i == stl_pkg::ChDash);
    flags_o.file_start  = (byte_i == stl_pkg::ChDot) || (byte_i == stl_pkg::ChSlash);
    flags_o.dollar      = (byte_i == stl_pkg::ChDollar);
  end

endmodule

[hw/rtl/stl_lex_core.sv]
// stl_lex_core: open-token class and position registers plus the per-byte
// continue/start decision. Depends on stl_pkg.
module stl_lex_core #(
  parameter int unsigned OFFSET_BITS = stl_pkg::OffsetBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  stl_pkg::char_flags_t       flags_i,
  output logic [stl_pkg::ClassW-1:0] res_class_o,
  output logic                       res_start_o,
  output logic [OFFSET_BITS-1:0]     res_offset_o,
  output logic                       res_eoi_o
);

  stl_pkg::class_e        class_q, class_d, first_cls;
  logic [OFFSET_BITS-1:0] cnt_q, cnt_d;
  logic                   cont;

  always_comb begin
    case (class_q)
      stl_pkg::CLS_SPACE:    cont = flags_i.space;
      stl_pkg::CLS_OPTION:   cont = flags_i.option_char;
      stl_pkg::CLS_FILE:     cont = flags_i.file_char;
      stl_pkg::CLS_WORD:     cont = flags_i.word_char;
      stl_pkg::CLS_VARIABLE: cont = flags_i.letter;
      stl_pkg::CLS_OTHER:    cont = !flags_i.zero && !flags_i.space;
      default:               cont = 1'b0;  // idle, newline
    endcase
  end

  always_comb begin
    if (flags_i.space)           first_cls = stl_pkg::CLS_SPACE;
    else if (flags_i.newline)    first_cls = stl_pkg::CLS_NEWLINE;
    else if (flags_i.dash)       first_cls = stl_pkg::CLS_OPTION;
    else if (flags_i.file_start) first_cls = stl_pkg::CLS_FILE;
    else if (flags_i.dollar)     first_cls = stl_pkg::CLS_VARIABLE;
    else if (flags_i.word_start) first_cls = stl_pkg::CLS_WORD;
    else                         first_cls = stl_pkg::CLS_OTHER;
  end

  always_comb begin
    res_eoi_o   = 1'b0;
    res_start_o = 1'b0;
    if (flags_i.zero) begin
      class_d   = stl_pkg::CLS_IDLE;
      cnt_d     = '0;
      res_eoi_o = 1'b1;
    end else if (cont) begin
      class_d = class_q;
      cnt_d   = (cnt_q == {OFFSET_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;
    end else begin
      class_d     = first_cls;
      cnt_d       = '0;
      res_start_o = 1'b1;
    end
    res_class_o  = flags_i.zero ? stl_pkg::CLS_OTHER : class_d;
    res_offset_o = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q <= stl_pkg::CLS_IDLE;
      cnt_q   <= '0;
    end else if (adv_i) begin
      class_q <= class_d;
      cnt_q   <= cnt_d;
    end
  end

  a_zero_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && flags_i.zero |=> class_q == stl_pkg::CLS_IDLE && cnt_q == '0)
    else $error("zero byte did not return lexer to idle");

  a_start_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_start_o |=> cnt_q == '0)
    else $error("new token did not restart position");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    class_q == stl_pkg::CLS_IDLE |-> cnt_q == '0)
    else $error("position nonzero while idle");

  a_newline_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    class_q == stl_pkg::CLS_NEWLINE |-> !cont && cnt_q == '0)
    else $error("newline token longer than one byte");

  a_continue_counts_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !flags_i.zero && !res_start_o |=> cnt_q != '0)
    else $error("continuation byte did not advance position");

endmodule

[hw/rtl/shell_token_lexer.sv]
// shell_token_lexer: top level. Input byte register, lexer core, result
// register. Depends on stl_pkg, stl_if, stl_char_decode, stl_lex_core.
//
//  channel | modport             | payload
//  in_i    | stl_byte_if.sink    | in_byte
//  out_o   | stl_token_if.source | token_class, token_start, token_offset,
//          |                     | end_of_input
//
// One byte per cycle while out_o is not stalled; a byte passes the input
// register, then the result register, before its result is valid.
// The class/position registers update as a byte moves into the result
// register, so the next byte sees them in the following cycle.
// Reset puts the lexer idle with position zero and empties both registers.
// A stalled result holds; the input register still takes a byte while empty.
module shell_token_lexer #(
  parameter int unsigned OFFSET_BITS = stl_pkg::OffsetBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  stl_byte_if.sink                 in_i,
  stl_token_if.source              out_o
);

  logic                       s1_vld_q;
  logic [stl_pkg::ByteW-1:0]  s1_byte_q;
  logic                       out_vld_q;
  logic [stl_pkg::ClassW-1:0] out_class_q;
  logic                       out_start_q;
  logic [OFFSET_BITS-1:0]     out_offset_q;
  logic                       out_eoi_q;

  logic                       out_free, adv;
  stl_pkg::char_flags_t       flags;
  logic [stl_pkg::ClassW-1:0] res_class;
  logic                       res_start;
  logic [OFFSET_BITS-1:0]     res_offset;
  logic                       res_eoi;

  assign out_free = !out_vld_q || out_o.ready;
  assign adv      = s1_vld_q && out_free;
  assign in_i.ready = !s1_vld_q || out_free;

  stl_char_decode u_decode (
    .byte_i  (s1_byte_q),
    .flags_o (flags)
  );

  stl_lex_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .flags_i      (flags),
    .res_class_o  (res_class),
    .res_start_o  (res_start),
    .res_offset_o (res_offset),
    .res_eoi_o    (res_eoi)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_vld_q <= in_i.valid;
      if (out_free) out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) s1_byte_q <= in_i.in_byte;
    if (adv) begin
      out_class_q  <= res_class;
      out_start_q  <= res_start;
      out_offset_q <= res_offset;
      out_eoi_q    <= res_eoi;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.token_class  = out_class_q;
  assign out_o.token_start  = out_start_q;
  assign out_o.token_offset = out_offset_q;
  assign out_o.end_of_input = out_eoi_q;

endmodule

[test/token_checker.sv]
// token_checker: watches the byte and token channels of the shell token lexer,
// predicts each token label and compares it with what comes out.
// Depends on stl_pkg and stl_if.
module token_checker #(
  parameter int unsigned OFFSET_BITS = stl_pkg::OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stl_byte_if         byte_ch,
  stl_token_if        tok_ch,
  output int unsigned err_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [stl_pkg::ByteW-1:0] byte_t;

  typedef struct packed {
    stl_pkg::class_e        cls;
    logic                   start;
    logic [OFFSET_BITS-1:0] offset;
    logic                   eoi;
  } token_label_t;

  token_label_t           label_q[$];
  stl_pkg::class_e        open_class;
  logic [OFFSET_BITS-1:0] open_pos;
  int unsigned            err_count;

  assign err_count_o = err_count;

  function automatic logic is_letter(byte_t c);
    return c >= stl_pkg::ChUpperA && c <= stl_pkg::ChLowerZ;
  endfunction

  function automatic logic is_blank(byte_t c);
    return c == stl_pkg::ChSpace || c == stl_pkg::ChTab;
  endfunction

  function automatic logic is_word_char(byte_t c);
    return c == stl_pkg::ChUnder || is_letter(c) || c == stl_pkg::ChDollar ||
           c == stl_pkg::ChDash;
  endfunction

  // Labels one byte and advances the open token.
  function automatic token_label_t label_byte(byte_t c);
    token_label_t lbl;
    logic         cont;
    lbl     = '0;
    lbl.cls = stl_pkg::CLS_OTHER;
    if (c == stl_pkg::ChNul) begin
      open_class = stl_pkg::CLS_IDLE;
      open_pos   = '0;
      lbl.eoi    = 1'b1;
      return lbl;
    end
    case (open_class)
      stl_pkg::CLS_SPACE:    cont = is_blank(c);
      stl_pkg::CLS_OPTION:   cont = is_word_char(c) || c == stl_pkg::ChEq;
      stl_pkg::CLS_FILE:     cont = is_word_char(c) || c == stl_pkg::ChDot ||
                                    c == stl_pkg::ChSlash;
      stl_pkg::CLS_WORD:     cont = is_word_char(c);
      stl_pkg::CLS_VARIABLE: cont = is_letter(c);
      stl_pkg::CLS_OTHER:    cont = !is_blank(c);
      default:               cont = 1'b0;
    endcase
    if (cont) begin
      if (open_pos != '1) open_pos = open_pos + 1'b1;
    end else begin
      open_pos  = '0;
      lbl.start = 1'b1;
      if (is_blank(c))                   open_class = stl_pkg::CLS_SPACE;
      else if (c == stl_pkg::ChNl)       open_class = stl_pkg::CLS_NEWLINE;
      else if (c == stl_pkg::ChDash)     open_class = stl_pkg::CLS_OPTION;
      else if (c == stl_pkg::ChDot || c == stl_pkg::ChSlash)
                                         open_class = stl_pkg::CLS_FILE;
      else if (c == stl_pkg::ChDollar)   open_class = stl_pkg::CLS_VARIABLE;
      else if (c == stl_pkg::ChUnder || is_letter(c))
                                         open_class = stl_pkg::CLS_WORD;
      else                               open_class = stl_pkg::CLS_OTHER;
    end
    lbl.cls    = open_class;
    lbl.offset = open_pos;
    return lbl;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    token_label_t want;
    token_label_t got;
    if (!rst_ni) begin
      label_q.delete();
      open_class = stl_pkg::CLS_IDLE;
      open_pos   = '0;
      err_count  = 0;
      pending_o  = 0;
    end else begin
      // results leave before the byte of this edge is labeled
      if (tok_ch.valid && tok_ch.ready) begin
        got.cls    = stl_pkg::class_e'(tok_ch.token_class);
        got.start  = tok_ch.token_start;
        got.offset = tok_ch.token_offset;
        got.eoi    = tok_ch.end_of_input;
        if (label_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%t: token transfer with nothing pending: %s",
                     $realtime,
                     $sformatf("cls=%0d start=%0d off=%0d eoi=%0d",
                               got.cls, got.start, got.offset, got.eoi));
        end else begin
          want = label_q.pop_front();
          if (got.cls != want.cls || got.start != want.start ||
              got.offset != want.offset || got.eoi != want.eoi) begin
            err_count++;
            if (err_count <= 10)
              $display("%t: token mismatch: exp %s, got %s", $realtime,
                       $sformatf("cls=%0d start=%0d off=%0d eoi=%0d",
                                 want.cls, want.start, want.offset, want.eoi),
                       $sformatf("cls=%0d start=%0d off=%0d eoi=%0d",
                                 got.cls, got.start, got.offset, got.eoi));
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready)
        label_q.push_back(label_byte(byte_ch.in_byte));
      pending_o = label_q.size();
    end
  end

endmodule

[test/testbench.sv]
// testbench: drives bytes into the shell token lexer with random gaps and
// stalls the token side at random; token_checker does the comparison.
// Depends on stl_pkg, stl_if, token_checker and the lexer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [stl_pkg::ByteW-1:0] byte_t;

  localparam int unsigned OffsetW    = 16;
  localparam int unsigned RandBytes  = 800;
  localparam int unsigned CycleLimit = 1000000;

  localparam byte_t Directed[25] = '{
    stl_pkg::ChNul, stl_pkg::ChDash, "a", stl_pkg::ChEq, "b", stl_pkg::ChSpace,
    stl_pkg::ChTab, stl_pkg::ChNl, stl_pkg::ChDot, stl_pkg::ChSlash, "x",
    stl_pkg::ChDash, stl_pkg::ChDollar, stl_pkg::ChUpperA, stl_pkg::ChLowerZ,
    stl_pkg::ChUnder, "w", stl_pkg::ChDollar, stl_pkg::ChDash,
    8'h80, stl_pkg::ChNl, 8'hFF, 8'h40, 8'h7B, stl_pkg::ChNul
  };

  logic        clk;
  logic        rst_n;
  logic        calm;
  int unsigned err_count;
  int unsigned pending;
  int unsigned sent_count;

  stl_byte_if                           byte_ch ();
  stl_token_if #(.OFFSET_BITS(OffsetW)) tok_ch ();

  shell_token_lexer #(.OFFSET_BITS(OffsetW)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (tok_ch)
  );

  token_checker #(.OFFSET_BITS(OffsetW)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .byte_ch     (byte_ch),
    .tok_ch      (tok_ch),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int unsigned pick_len();
    if ($urandom_range(0, 4) == 0) return $urandom_range(6, 40);
    return $urandom_range(1, 5);
  endfunction

  function automatic byte_t pick_letter();
    return byte_t'($urandom_range(stl_pkg::ChUpperA, stl_pkg::ChLowerZ));
  endfunction

  function automatic byte_t pick_word_char();
    case ($urandom_range(0, 9))
      0:       return stl_pkg::ChUnder;
      1:       return stl_pkg::ChDollar;
      2:       return stl_pkg::ChDash;
      default: return pick_letter();
    endcase
  endfunction

  function automatic byte_t pick_other_char();
    case ($urandom_range(0, 2))
      0:       return byte_t'($urandom_range(8'h80, 8'hFF));
      1:       return byte_t'($urandom_range(8'h30, 8'h39));
      default: return byte_t'($urandom_range(8'h21, 8'h40));
    endcase
  endfunction

  // valid stays high into the next byte when no gap follows
  task automatic send_byte(input byte_t b);
    int unsigned gap;
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(negedge clk); while (!byte_ch.ready);
    @(posedge clk);
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, wait for every pending token, resume on a rising edge
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic send_token(input stl_pkg::class_e kind);
    int unsigned len;
    len = pick_len();
    case (kind)
      stl_pkg::CLS_SPACE:
        repeat (len) send_byte($urandom_range(0, 1) ? stl_pkg::ChSpace : stl_pkg::ChTab);
      stl_pkg::CLS_NEWLINE:
        send_byte(stl_pkg::ChNl);
      stl_pkg::CLS_OPTION: begin
        send_byte(stl_pkg::ChDash);
        repeat (len - 1)
          send_byte(($urandom_range(0, 5) == 0) ? stl_pkg::ChEq : pick_word_char());
      end
      stl_pkg::CLS_FILE: begin
        send_byte($urandom_range(0, 1) ? stl_pkg::ChDot : stl_pkg::ChSlash);
        repeat (len - 1) begin
          case ($urandom_range(0, 5))
            0:       send_byte(stl_pkg::ChDot);
            1:       send_byte(stl_pkg::ChSlash);
            default: send_byte(pick_word_char());
          endcase
        end
      end
      stl_pkg::CLS_WORD: begin
        send_byte($urandom_range(0, 3) == 0 ? stl_pkg::ChUnder : pick_letter());
        repeat (len - 1) send_byte(pick_word_char());
      end
      stl_pkg::CLS_VARIABLE: begin
        send_byte(stl_pkg::ChDollar);
        repeat (len - 1) send_byte(pick_letter());
      end
      default:
        repeat (len) send_byte(pick_other_char());
    endcase
  endtask

  // a command line: tokens, each followed by a space half the time, usually closed by NUL or newline
  task automatic send_line();
    int unsigned ntok;
    int unsigned r;
    ntok = $urandom_range(1, 8);
    repeat (ntok) begin
      send_token(stl_pkg::class_e'($urandom_range(stl_pkg::CLS_OTHER,
                                                  stl_pkg::CLS_VARIABLE)));
      if ($urandom_range(0, 1)) send_byte(stl_pkg::ChSpace);
    end
    r = $urandom_range(0, 9);
    if (r < 6) send_byte(stl_pkg::ChNul);
    else if (r < 9) send_byte(stl_pkg::ChNl);
  endtask

  initial begin
    int unsigned len;
    tok_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      len = pick_gap();
      if (len == 0) begin
        tok_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        tok_ch.ready <= 1'b0;
        repeat (len) @(posedge clk);
        tok_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    calm            = 1'b0;
    sent_count      = 0;
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (Directed[i]) send_byte(Directed[i]);
    wait_drained();

    sent_count = 0;
    while (sent_count < RandBytes) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 12)) send_byte(byte_t'($urandom_range(0, 255)));
      end else begin
        send_line();
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    calm = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    if (err_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
